### sv/pspc_pkg.sv
// Shared constants, stage types and Pauli helper functions for the string multiplier.
package pspc_pkg;

	localparam int QUBITS    = 32;
	localparam int LANES     = 32;
	localparam int STR_W     = 2 * LANES;
	localparam int LEN_W     = 6;
	localparam int GROUP_SZ  = 8;
	localparam int GROUPS    = LANES / GROUP_SZ;
	localparam int GCNT_W    = $clog2(GROUP_SZ + 1);

	localparam logic [1:0] PAULI_I = 2'd0;
	localparam logic [1:0] PAULI_X = 2'd1;
	localparam logic [1:0] PAULI_Y = 2'd2;
	localparam logic [1:0] PAULI_Z = 2'd3;

	localparam logic [1:0] PH_ZERO  = 2'd0;
	localparam logic [1:0] PH_PLUS  = 2'd1;
	localparam logic [1:0] PH_MINUS = 2'd3;

	typedef logic [STR_W-1:0] pstr_t;
	typedef logic [LEN_W-1:0] plen_t;

	typedef struct packed {
		pstr_t             prod;
		logic [LANES-1:0]  nz;
		logic [STR_W-1:0]  contrib;
		logic [1:0]        phase_base;
		plen_t             len;
	} s1_t;

	typedef struct packed {
		pstr_t                         prod;
		logic [GROUPS-1:0][GCNT_W-1:0] wpart;
		logic [GROUPS-1:0][1:0]        ppart;
		logic [1:0]                    phase_base;
		plen_t                         len;
	} s2_t;

	// Phase picked up by one qubit pair, in units of i mod 4.
	function automatic logic [1:0] pauli_phase(input logic [1:0] a, input logic [1:0] b);
		logic [1:0] r;
		r = PH_ZERO;
		case ({a, b})
			{PAULI_X, PAULI_Y}, {PAULI_Y, PAULI_Z}, {PAULI_Z, PAULI_X}: r = PH_PLUS;
			{PAULI_Y, PAULI_X}, {PAULI_Z, PAULI_Y}, {PAULI_X, PAULI_Z}: r = PH_MINUS;
			default: r = PH_ZERO;
		endcase
		return r;
	endfunction

	function automatic plen_t sat_len(input plen_t l);
		return (l > plen_t'(QUBITS)) ? plen_t'(QUBITS) : l;
	endfunction

endpackage

### sv/pspc_if.sv
// Valid/ready channel interfaces for operand pairs and product results.
interface pspc_in_if import pspc_pkg::*;;
	logic       valid;
	logic       ready;
	pstr_t      string_a;
	logic [1:0] phase_a;
	plen_t      length_a;
	pstr_t      string_b;
	logic [1:0] phase_b;
	plen_t      length_b;

	modport source (output valid, string_a, phase_a, length_a, string_b, phase_b, length_b,
		input ready);
	modport sink (input valid, string_a, phase_a, length_a, string_b, phase_b, length_b,
		output ready);
endinterface

interface pspc_out_if import pspc_pkg::*;;
	logic       valid;
	logic       ready;
	pstr_t      product_string;
	logic [1:0] product_phase;
	plen_t      product_length;
	logic       strings_commute;
	plen_t      product_weight;
	logic       product_identity;

	modport source (output valid, product_string, product_phase, product_length,
		strings_commute, product_weight, product_identity, input ready);
	modport sink (input valid, product_string, product_phase, product_length,
		strings_commute, product_weight, product_identity, output ready);
endinterface

### sv/pauli_string_product_commute.sv
// Pauli string multiplier with phase, commutation test, weight and identity flag.
// Throughput: one word per cycle; three register stages advance together and
// hold in place while the output word waits for ready.
// Reset: arst_n clears all stage valid bits at once; payload registers are not reset.
module pauli_string_product_commute import pspc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	pspc_in_if.sink    req,
	pspc_out_if.source rsp
);
	logic en;
	logic valid_s1, valid_s2;
	s1_t  data_s1;
	s2_t  data_s2;

	assign en = !rsp.valid || rsp.ready;
	assign req.ready = en;

	pspc_lanes u_lanes (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.vin      (req.valid),
		.string_a (req.string_a),
		.phase_a  (req.phase_a),
		.length_a (req.length_a),
		.string_b (req.string_b),
		.phase_b  (req.phase_b),
		.length_b (req.length_b),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1)
	);

	pspc_tally u_tally (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1),
		.valid_s2 (valid_s2),
		.data_s2  (data_s2)
	);

	pspc_final u_final (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.valid_s2 (valid_s2),
		.data_s2  (data_s2),
		.rsp      (rsp)
	);
endmodule

### sv/pspc_lanes.sv
// Stage 1: length masking and per-qubit product, weight and phase terms.
module pspc_lanes import pspc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic       vin,
	input  pstr_t      string_a,
	input  logic [1:0] phase_a,
	input  plen_t      length_a,
	input  pstr_t      string_b,
	input  logic [1:0] phase_b,
	input  plen_t      length_b,
	output logic       valid_s1,
	output s1_t        data_s1
);
	plen_t la, lb;
	s1_t   d;

	always_comb begin
		logic [1:0] a, b, p;
		la = sat_len(length_a);
		lb = sat_len(length_b);
		d = '0;
		d.len = (la > lb) ? la : lb;
		d.phase_base = phase_a + phase_b;
		for (int q = 0; q < LANES; q++) begin
			a = (plen_t'(q) < la) ? string_a[2*q +: 2] : PAULI_I;
			b = (plen_t'(q) < lb) ? string_b[2*q +: 2] : PAULI_I;
			p = a ^ b;
			d.prod[2*q +: 2] = p;
			d.nz[q] = (p != PAULI_I);
			d.contrib[2*q +: 2] = pauli_phase(a, b);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= vin;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s1 <= d;
		end
	end
endmodule

### sv/pspc_tally.sv
// Stage 2: per-group weight counts and phase sums over eight qubits each.
module pspc_tally import pspc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic valid_s1,
	input  s1_t  data_s1,
	output logic valid_s2,
	output s2_t  data_s2
);
	s2_t d;

	always_comb begin
		d = '0;
		d.prod = data_s1.prod;
		d.phase_base = data_s1.phase_base;
		d.len = data_s1.len;
		for (int g = 0; g < GROUPS; g++) begin
			for (int k = 0; k < GROUP_SZ; k++) begin
				d.wpart[g] = d.wpart[g] + GCNT_W'(data_s1.nz[g*GROUP_SZ + k]);
				d.ppart[g] = d.ppart[g] + data_s1.contrib[2*(g*GROUP_SZ + k) +: 2];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s2 <= d;
		end
	end
endmodule

### sv/pspc_final.sv
// Stage 3: final weight and phase sums, commutation and identity flags.
module pspc_final import pspc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic valid_s2,
	input  s2_t  data_s2,
	pspc_out_if.source rsp
);
	plen_t      weight;
	logic [1:0] tc;
	logic [1:0] phase;

	always_comb begin
		weight = '0;
		tc = '0;
		for (int g = 0; g < GROUPS; g++) begin
			weight = weight + LEN_W'(data_s2.wpart[g]);
			tc = tc + data_s2.ppart[g];
		end
		phase = data_s2.phase_base + tc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.valid <= 1'b0;
		end else if (en) begin
			rsp.valid <= valid_s2;
		end
	end

	// every anticommuting pair adds an odd phase term, so the parity is tc[0]
	always_ff @(posedge clk) begin
		if (en) begin
			rsp.product_string   <= data_s2.prod;
			rsp.product_phase    <= phase;
			rsp.product_length   <= data_s2.len;
			rsp.strings_commute  <= ~tc[0];
			rsp.product_weight   <= weight;
			rsp.product_identity <= (data_s2.prod == '0) && (phase == PH_ZERO);
		end
	end
endmodule
